@@ rtl/pps_pkg.sv @@
// ----------------------------------------------------------------------------
// pps_pkg
// Shared constants, codes and types for the preemptive priority scheduler.
// ----------------------------------------------------------------------------
package pps_pkg;

	// table geometry and field widths
	localparam int SLOTS     = 16;
	localparam int TIME_BITS = 16;
	localparam int PRIO_BITS = 8;
	localparam int SLOT_BITS = $clog2(SLOTS);
	localparam int CNT_BITS  = $clog2(SLOTS + 1);
	localparam int OP_BITS   = 2;
	localparam int ST_BITS   = 3;

	localparam logic [TIME_BITS-1:0] TIME_MAX   = '1;
	localparam logic [CNT_BITS-1:0]  SLOTS_CNT  = CNT_BITS'(SLOTS);

	// op codes (op bit 1 set means tick)
	localparam logic [OP_BITS-1:0] OP_CLEAR = 2'd0;
	localparam logic [OP_BITS-1:0] OP_LOAD  = 2'd1;

	// status codes
	localparam logic [ST_BITS-1:0] ST_OK   = 3'd0;
	localparam logic [ST_BITS-1:0] ST_FULL = 3'd1;
	localparam logic [ST_BITS-1:0] ST_ZERO = 3'd2;
	localparam logic [ST_BITS-1:0] ST_IDLE = 3'd3;
	localparam logic [ST_BITS-1:0] ST_RAN  = 3'd4;

	// best candidate handed from cell to cell
	typedef struct packed {
		logic                 valid;
		logic [PRIO_BITS-1:0] prio;
		logic [TIME_BITS-1:0] arrival;
		logic [TIME_BITS-1:0] burst;
		logic [TIME_BITS-1:0] remaining;
		logic [SLOT_BITS-1:0] slot;
	} cand_t;

	// control broadcast to all cells
	typedef struct packed {
		logic                 clear;
		logic                 load;
		logic [SLOT_BITS-1:0] load_slot;
		logic                 dec;
		logic                 finish;
		logic [SLOT_BITS-1:0] dec_slot;
	} cell_ctl_t;

endpackage

@@ rtl/pps_cell.sv @@
// ----------------------------------------------------------------------------
// pps_cell
// One job slot: holds the job's entry and passes the better of its own job
// (when eligible) and the incoming candidate to the next cell each cycle.
// ----------------------------------------------------------------------------
module pps_cell import pps_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [SLOT_BITS-1:0] idx,
	input  cell_ctl_t            ctl,
	input  logic [TIME_BITS-1:0] load_arrival,
	input  logic [TIME_BITS-1:0] load_burst,
	input  logic [PRIO_BITS-1:0] load_prio,
	input  logic [CNT_BITS-1:0]  job_count,
	input  logic [TIME_BITS-1:0] cur_time,
	input  cand_t                cin,
	output cand_t                cout
);

	logic [TIME_BITS-1:0] arr_q;
	logic [TIME_BITS-1:0] burst_q;
	logic [TIME_BITS-1:0] rem_q;
	logic [PRIO_BITS-1:0] prio_q;
	logic                 fin_q;
	cand_t                cand_q;

	logic  loaded;
	logic  eligible;
	logic  better;
	cand_t own;

	// eligibility and comparison against the incoming candidate
	assign loaded   = {1'b0, idx} < job_count;
	assign eligible = loaded && !fin_q && (arr_q <= cur_time);
	assign better   = eligible && (!cin.valid || (prio_q < cin.prio) ||
		((prio_q == cin.prio) && (arr_q < cin.arrival)));

	always_comb begin
		own.valid     = 1'b1;
		own.prio      = prio_q;
		own.arrival   = arr_q;
		own.burst     = burst_q;
		own.remaining = rem_q;
		own.slot      = idx;
	end

	// candidate register toward the next cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cand_q <= '0;
		end else begin
			cand_q <= better ? own : cin;
		end
	end

	assign cout = cand_q;

	// finished flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fin_q <= 1'b0;
		end else if (ctl.clear) begin
			fin_q <= 1'b0;
		end else if (ctl.load && (ctl.load_slot == idx)) begin
			fin_q <= 1'b0;
		end else if (ctl.dec && ctl.finish && (ctl.dec_slot == idx)) begin
			fin_q <= 1'b1;
		end
	end

	// job entry
	always_ff @(posedge clk) begin
		if (ctl.load && (ctl.load_slot == idx)) begin
			arr_q   <= load_arrival;
			burst_q <= load_burst;
			rem_q   <= load_burst;
			prio_q  <= load_prio;
		end else if (ctl.dec && (ctl.dec_slot == idx)) begin
			rem_q <= rem_q - TIME_BITS'(1);
		end
	end

endmodule

@@ rtl/preemptive_priority_scheduler_top.sv @@
// ----------------------------------------------------------------------------
// preemptive_priority_scheduler_top
// Job table as a row of slot cells; a tick sends the best candidate down the
// row one cell per cycle, then runs the winner for one time unit.
// ----------------------------------------------------------------------------
// a clear or load goes through the EXEC state, a tick through SCAN and FINISH;
// the result is registered into the output register once that is free
// one word at a time: a new word is taken only in the idle state;
// a tick walks the candidate through the SLOTS cells of the row
// reset: empty table, time zero, all finished flags cleared, no word pending
module preemptive_priority_scheduler_top import pps_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [OP_BITS-1:0]   op,
	input  logic [TIME_BITS-1:0] arrival_time,
	input  logic [TIME_BITS-1:0] burst_length,
	input  logic [PRIO_BITS-1:0] job_priority,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [ST_BITS-1:0]   status,
	output logic [SLOT_BITS-1:0] job_slot,
	output logic                 job_finished,
	output logic [TIME_BITS-1:0] finish_time,
	output logic [TIME_BITS-1:0] turnaround_time,
	output logic [TIME_BITS-1:0] waiting_time,
	output logic                 all_done,
	output logic [TIME_BITS-1:0] time_now
);

	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_EXEC   = 2'd1;
	localparam logic [1:0] S_SCAN   = 2'd2;
	localparam logic [1:0] S_FINISH = 2'd3;

	logic [1:0]           state_q;
	logic [SLOT_BITS-1:0] scan_cnt_q;
	logic [OP_BITS-1:0]   op_q;
	logic [TIME_BITS-1:0] arr_q;
	logic [TIME_BITS-1:0] burst_q;
	logic [PRIO_BITS-1:0] prio_q;
	logic [CNT_BITS-1:0]  job_cnt_q;
	logic [CNT_BITS-1:0]  done_cnt_q;
	logic [TIME_BITS-1:0] time_q;
	logic                 out_valid_q;

	logic [ST_BITS-1:0]   status_q;
	logic [SLOT_BITS-1:0] slot_q;
	logic                 fin_q;
	logic [TIME_BITS-1:0] ft_q;
	logic [TIME_BITS-1:0] tat_q;
	logic [TIME_BITS-1:0] wt_q;
	logic                 all_done_q;
	logic [TIME_BITS-1:0] time_now_q;

	cand_t                chain [SLOTS+1];
	cand_t                best;
	cell_ctl_t            ctl;

	logic                 accept;
	logic                 out_free;
	logic                 commit;
	logic                 is_full;
	logic                 is_zero;
	logic [TIME_BITS-1:0] next_time;
	logic [TIME_BITS-1:0] turn;
	logic                 finishing;

	logic [ST_BITS-1:0]   n_status;
	logic [SLOT_BITS-1:0] n_slot;
	logic                 n_fin;
	logic [TIME_BITS-1:0] n_ft;
	logic [TIME_BITS-1:0] n_tat;
	logic [TIME_BITS-1:0] n_wt;
	logic [CNT_BITS-1:0]  n_job_cnt;
	logic [CNT_BITS-1:0]  n_done_cnt;
	logic [TIME_BITS-1:0] n_time;

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;
	assign commit   = out_free && ((state_q == S_EXEC) || (state_q == S_FINISH));

	// row of slot cells
	assign chain[0] = '0;
	assign best     = chain[SLOTS];

	genvar gi;
	generate
		for (gi = 0; gi < SLOTS; gi++) begin : g_cell
			pps_cell u_cell (
				.clk          (clk),
				.arst_n       (arst_n),
				.idx          (SLOT_BITS'(gi)),
				.ctl          (ctl),
				.load_arrival (arr_q),
				.load_burst   (burst_q),
				.load_prio    (prio_q),
				.job_count    (job_cnt_q),
				.cur_time     (time_q),
				.cin          (chain[gi]),
				.cout         (chain[gi+1])
			);
		end
	endgenerate

	// tick arithmetic
	assign next_time = (time_q == TIME_MAX) ? TIME_MAX : time_q + TIME_BITS'(1);
	assign turn      = next_time - best.arrival;
	assign finishing = best.valid && (best.remaining == TIME_BITS'(1));
	assign is_full   = (job_cnt_q == SLOTS_CNT);
	assign is_zero   = (burst_q == '0);

	// result and next state of the counters
	always_comb begin
		n_status   = ST_OK;
		n_slot     = '0;
		n_fin      = 1'b0;
		n_ft       = '0;
		n_tat      = '0;
		n_wt       = '0;
		n_job_cnt  = job_cnt_q;
		n_done_cnt = done_cnt_q;
		n_time     = time_q;
		ctl        = '0;
		if (state_q == S_FINISH) begin
			n_time = next_time;
			if (best.valid) begin
				n_status     = ST_RAN;
				n_slot       = best.slot;
				ctl.dec      = commit;
				ctl.finish   = finishing;
				ctl.dec_slot = best.slot;
				if (finishing) begin
					n_fin      = 1'b1;
					n_ft       = next_time;
					n_tat      = turn;
					n_wt       = (turn >= best.burst) ? turn - best.burst : '0;
					n_done_cnt = done_cnt_q + CNT_BITS'(1);
				end
			end else begin
				n_status = ST_IDLE;
			end
		end else begin
			case (op_q)
				OP_CLEAR: begin
					ctl.clear  = commit;
					n_job_cnt  = '0;
					n_done_cnt = '0;
					n_time     = '0;
				end
				OP_LOAD: begin
					if (is_full) begin
						n_status = ST_FULL;
					end else if (is_zero) begin
						n_status = ST_ZERO;
					end else begin
						ctl.load      = commit;
						ctl.load_slot = job_cnt_q[SLOT_BITS-1:0];
						n_slot        = job_cnt_q[SLOT_BITS-1:0];
						n_job_cnt     = job_cnt_q + CNT_BITS'(1);
					end
				end
				default: begin
					n_status = ST_OK;
				end
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			scan_cnt_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					scan_cnt_q <= '0;
					if (accept) begin
						state_q <= op[1] ? S_SCAN : S_EXEC;
					end
				end
				S_EXEC: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				S_SCAN: begin
					scan_cnt_q <= scan_cnt_q + SLOT_BITS'(1);
					if (scan_cnt_q == SLOT_BITS'(SLOTS - 1)) begin
						state_q <= S_FINISH;
					end
				end
				S_FINISH: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// accepted word
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q    <= op;
			arr_q   <= arrival_time;
			burst_q <= burst_length;
			prio_q  <= job_priority;
		end
	end

	// counters and time
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			job_cnt_q  <= '0;
			done_cnt_q <= '0;
			time_q     <= '0;
		end else if (commit) begin
			job_cnt_q  <= n_job_cnt;
			done_cnt_q <= n_done_cnt;
			time_q     <= n_time;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (commit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			status_q   <= n_status;
			slot_q     <= n_slot;
			fin_q      <= n_fin;
			ft_q       <= n_ft;
			tat_q      <= n_tat;
			wt_q       <= n_wt;
			all_done_q <= (n_done_cnt == n_job_cnt);
			time_now_q <= n_time;
		end
	end

	assign out_valid       = out_valid_q;
	assign status          = status_q;
	assign job_slot        = slot_q;
	assign job_finished    = fin_q;
	assign finish_time     = ft_q;
	assign turnaround_time = tat_q;
	assign waiting_time    = wt_q;
	assign all_done        = all_done_q;
	assign time_now        = time_now_q;

endmodule
